// ===== design/ilws_pkg.sv =====
// ----------------------------------------------------------------------------
// ilws_pkg
// Shared widths, operation codes and status codes for the indexed list.
// ----------------------------------------------------------------------------
package ilws_pkg;

  localparam int DEPTH   = 64;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);

  localparam int MODE_W  = 3;
  localparam int POS_W   = 6;
  localparam int DATA_W  = 32;
  localparam int FI_W    = 7;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 7;
  localparam int CFG_W   = 7;

  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CFG_W-1:0] INIT_CAP_RESET = CFG_W'(4);
  localparam logic             REG_INIT_CAP   = 1'b0;

  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EDIT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GET    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [ST_W-1:0] ST_BADINDEX = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  localparam logic signed [FI_W-1:0] FI_NONE = '1;

  // Capacity value for a written register: zero acts as one, and anything
  // above the store depth acts as the depth.
  function automatic logic [CNT_W-1:0] clamp_cap(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== design/indexed_list_with_shift_top.sv =====
// ----------------------------------------------------------------------------
// indexed_list_with_shift_top
// Ordered list of signed words in a single-port-write, registered-read
// memory, with capacity tracking. One sequencer steps the memory port,
// the pointer adder and the word comparator through each operation.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  in        in_valid / in_ready    in_mode, in_position, in_value
//  out       out_valid / out_ready  out_read_value, out_found_index,
//                                   out_status, out_element_count,
//                                   out_current_capacity
//  cfg       psel/penable/pwrite    paddr, pwdata, prdata (pready tied high)
//  Each moved or compared element costs one memory read and one step of the
//  shared pointer/compare unit. in_ready is high only while idle.
//  Reset is synchronous: list empty, capacity from the reset register value.
//  A stalled result waits in the output register; the sequencer holds.
// ----------------------------------------------------------------------------
module indexed_list_with_shift_top
  import ilws_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [MODE_W-1:0]         in_mode,
  input  logic [POS_W-1:0]          in_position,
  input  logic signed [DATA_W-1:0]  in_value,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  out_read_value,
  output logic signed [FI_W-1:0]    out_found_index,
  output logic [ST_W-1:0]           out_status,
  output logic [COUNT_W-1:0]        out_element_count,
  output logic [COUNT_W-1:0]        out_current_capacity,

  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [APB_DW-1:0]         pwdata,
  output logic [APB_DW-1:0]         prdata,
  output logic                      pready
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_SHRINK,
    S_GET_WAIT,
    S_FIND_RD,
    S_FIND_CMP,
    S_DONE
  } state_t;

  localparam int CAPD_W = CNT_W + 1;

  state_t                    state_r;
  logic [CNT_W-1:0]          ptr_r;
  logic [CNT_W-1:0]          pos_r;
  logic [DATA_W-1:0]         val_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          cap_r;
  logic [CFG_W-1:0]          init_cap_r;
  logic [DATA_W-1:0]         rd_r;
  logic signed [FI_W-1:0]    fi_r;
  logic [ST_W-1:0]           st_r;
  logic                      out_valid_r;
  logic [DATA_W-1:0]         out_rd_r;
  logic signed [FI_W-1:0]    out_fi_r;
  logic [ST_W-1:0]           out_st_r;
  logic [COUNT_W-1:0]        out_cnt_r;
  logic [COUNT_W-1:0]        out_cap_r;

  logic [DATA_W-1:0]         mem [DEPTH];
  logic [DATA_W-1:0]         rdata_r;
  logic                      mem_we;
  logic [IDX_W-1:0]          mem_waddr;
  logic [DATA_W-1:0]         mem_wdata;
  logic [IDX_W-1:0]          mem_raddr;

  logic [CNT_W-1:0]          in_pos;
  logic [CNT_W-1:0]          ptr_inc;
  logic [CNT_W-1:0]          ptr_dec;
  logic                      room_ok;
  logic [CAPD_W-1:0]         cap_dbl;
  logic [CNT_W-1:0]          cap_room;
  logic                      accept;
  logic                      cfg_wr;
  logic [CNT_W-1:0]          cfg_cap;

  state_t                    acc_next;
  logic [ST_W-1:0]           acc_st;
  logic [DATA_W-1:0]         acc_rd;

  assign in_pos   = CNT_W'(in_position);
  assign ptr_inc  = ptr_r + CNT_W'(1);
  assign ptr_dec  = ptr_r - CNT_W'(1);
  assign room_ok  = count_r < CNT_W'(DEPTH);
  assign cap_dbl  = {1'b0, cap_r} << 1;
  // Capacity after an append or insert makes room: doubles when full, capped at the depth.
  assign cap_room = (count_r < cap_r) ? cap_r :
                    (cap_dbl > CAPD_W'(DEPTH)) ? CNT_W'(DEPTH) : cap_dbl[CNT_W-1:0];

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_ready = (state_r == S_IDLE);

  assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_INIT_CAP);
  assign cfg_cap  = clamp_cap(pwdata[CFG_W-1:0]);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_INIT_CAP) ? APB_DW'(init_cap_r) : '0;

  // Status, read word and next state for a beat offered while idle.
  always_comb begin
    acc_next = S_DONE;
    acc_st   = ST_OK;
    acc_rd   = '0;
    case (in_mode)
      MODE_APPEND: begin
        if (!room_ok) begin
          acc_st = ST_FULL;
        end
      end
      MODE_INSERT: begin
        if (in_pos > count_r) begin
          acc_st = ST_BADINDEX;
        end else if (!room_ok) begin
          acc_st = ST_FULL;
        end else begin
          acc_next = S_INS_RD;
        end
      end
      MODE_EDIT: begin
        if (in_pos >= count_r) begin
          acc_st = ST_BADINDEX;
        end
      end
      MODE_DELETE: begin
        if (count_r == '0) begin
          acc_st = ST_EMPTY;
        end else if (in_pos >= count_r) begin
          acc_st = ST_BADINDEX;
        end else begin
          acc_next = S_DEL_RD;
        end
      end
      MODE_GET: begin
        if (count_r == '0) begin
          acc_st = ST_EMPTY;
          acc_rd = '1;
        end else if (in_pos >= count_r) begin
          acc_st = ST_BADINDEX;
          acc_rd = '1;
        end else begin
          acc_next = S_GET_WAIT;
        end
      end
      MODE_FIND: begin
        if (count_r == '0) begin
          acc_st = ST_EMPTY;
        end else begin
          acc_next = S_FIND_RD;
        end
      end
      default: begin
      end
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_r[IDX_W-1:0];
    mem_wdata = in_value;
    mem_raddr = in_position[IDX_W-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_APPEND && room_ok) begin
            mem_we = 1'b1;
          end else if (in_mode == MODE_EDIT && in_pos < count_r) begin
            mem_we    = 1'b1;
            mem_waddr = in_position[IDX_W-1:0];
          end
        end
      end
      S_INS_RD: begin
        mem_raddr = ptr_dec[IDX_W-1:0];
        if (ptr_r <= pos_r) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r[IDX_W-1:0];
          mem_wdata = val_r;
        end
      end
      S_INS_WR, S_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[IDX_W-1:0];
        mem_wdata = rdata_r;
      end
      S_DEL_RD:  mem_raddr = ptr_inc[IDX_W-1:0];
      S_FIND_RD: mem_raddr = ptr_r[IDX_W-1:0];
      S_SHRINK, S_GET_WAIT, S_FIND_CMP, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      init_cap_r  <= INIT_CAP_RESET;
      cap_r       <= clamp_cap(INIT_CAP_RESET);
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      pos_r       <= '0;
      st_r        <= ST_OK;
      fi_r        <= FI_NONE;
    end else begin
      // A taken result empties the output register unless the next one
      // is loaded at the same edge.
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pos_r   <= in_pos;
            val_r   <= in_value;
            rd_r    <= acc_rd;
            fi_r    <= FI_NONE;
            st_r    <= acc_st;
            state_r <= acc_next;
            if (acc_st == ST_OK) begin
              case (in_mode)
                MODE_APPEND: begin
                  cap_r   <= cap_room;
                  count_r <= count_r + CNT_W'(1);
                end
                MODE_INSERT: begin
                  cap_r <= cap_room;
                  ptr_r <= count_r;
                end
                MODE_DELETE: ptr_r <= in_pos;
                MODE_FIND:   ptr_r <= '0;
                default: begin
                end
              endcase
            end
          end
        end
        S_INS_RD: begin
          // Elements move up from the tail until the slot at pos_r is free.
          if (ptr_r > pos_r) begin
            state_r <= S_INS_WR;
          end else begin
            count_r <= count_r + CNT_W'(1);
            state_r <= S_DONE;
          end
        end
        S_INS_WR: begin
          ptr_r   <= ptr_dec;
          state_r <= S_INS_RD;
        end
        S_DEL_RD: begin
          if (ptr_inc < count_r) begin
            state_r <= S_DEL_WR;
          end else begin
            count_r <= count_r - CNT_W'(1);
            state_r <= S_SHRINK;
          end
        end
        S_DEL_WR: begin
          ptr_r   <= ptr_inc;
          state_r <= S_DEL_RD;
        end
        S_SHRINK: begin
          if (cap_r > CNT_W'(1) && (cap_r >> 1) >= count_r) begin
            cap_r <= cap_r >> 1;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_GET_WAIT: begin
          rd_r    <= rdata_r;
          state_r <= S_DONE;
        end
        S_FIND_RD: begin
          state_r <= S_FIND_CMP;
        end
        S_FIND_CMP: begin
          if (rdata_r == val_r) begin
            fi_r    <= FI_W'(ptr_r);
            state_r <= S_DONE;
          end else if (ptr_inc >= count_r) begin
            state_r <= S_DONE;
          end else begin
            ptr_r   <= ptr_inc;
            state_r <= S_FIND_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_rd_r    <= rd_r;
            out_fi_r    <= fi_r;
            out_st_r    <= st_r;
            out_cnt_r   <= COUNT_W'(count_r);
            out_cap_r   <= COUNT_W'(cap_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // Writes are to arrive only while idle, so they never race the sequencer; the block does not enforce it.
      if (cfg_wr) begin
        init_cap_r <= pwdata[CFG_W-1:0];
        cap_r      <= (cfg_cap < count_r) ? count_r : cfg_cap;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_read_value       = out_rd_r;
  assign out_found_index      = out_fi_r;
  assign out_status           = out_st_r;
  assign out_element_count    = out_cnt_r;
  assign out_current_capacity = out_cap_r;

endmodule

// ===== design/ilws_checker.sv =====
// ----------------------------------------------------------------------------
// ilws_checker
// Port-level checks on the indexed list, bound to the top level.
// ----------------------------------------------------------------------------
module ilws_checker
  import ilws_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_read_value,
  input logic signed [FI_W-1:0]   out_found_index,
  input logic [ST_W-1:0]          out_status,
  input logic [COUNT_W-1:0]       out_element_count,
  input logic [COUNT_W-1:0]       out_current_capacity
);

  // A held result keeps its read value, status and element count until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value)
      && $stable(out_status) && $stable(out_element_count))
    else $error("result changed while stalled");

  // Capacity always covers the elements held and never exceeds the depth.
  a_cap_covers: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_current_capacity >= out_element_count
      && out_current_capacity <= COUNT_W'(DEPTH))
    else $error("capacity below element count or above depth");

  // An empty-list status reports zero elements.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_element_count == '0)
    else $error("empty status with elements held");

  // A found index is always inside the list.
  a_found_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found_index != FI_NONE |->
      out_status == ST_OK && COUNT_W'(out_found_index) < out_element_count)
    else $error("found index outside the list");

  // in_ready is low in the cycle after a beat is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted back to back");

endmodule

bind indexed_list_with_shift_top ilws_checker u_ilws_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_read_value       (out_read_value),
  .out_found_index      (out_found_index),
  .out_status           (out_status),
  .out_element_count    (out_element_count),
  .out_current_capacity (out_current_capacity)
);
